@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

    // data and register widths
    localparam int DATA_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 4;

    // default window and replacement depths, in bytes
    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_REPLACE_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN   = 2'd3;

endpackage

@@ rtl/sfr_cell.sv @@
module sfr_cell (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_shift,
    input  logic [sfr_pkg::DATA_W-1:0]  i_in_byte,
    input  logic [sfr_pkg::DATA_W-1:0]  i_next_byte,
    input  logic [sfr_pkg::DATA_W-1:0]  i_pat_byte,
    output logic [sfr_pkg::DATA_W-1:0]  o_byte,
    output logic                        o_eq
);

    logic [sfr_pkg::DATA_W-1:0] r_byte;

    // held byte: written from the stream or taken from the right neighbor
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_in_byte;
        end else if (i_shift) begin
            r_byte <= i_next_byte;
        end
    end

    // compare against the pattern byte at this position
    assign o_byte = r_byte;
    assign o_eq   = (r_byte == i_pat_byte);

endmodule

@@ rtl/stream_find_replace.sv @@
// Streaming find-and-replace over a byte stream. Each input transaction carries one
// byte (tlast marks the final byte of a stream); the output stream is the input
// with every leftmost, non-overlapping occurrence of the pattern replaced by the
// replacement text. Output tuser[0] flags a real byte (0 only on a bare end
// marker), tuser[1] marks the last output of the stream, tlast marks the last
// output caused by an input byte. The window of candidate bytes is a row of
// MAX_PATTERN cells compared in parallel with the pattern and shifted one place per
// byte emitted from the window. An input byte passes an accept step, a decision
// step, an emit step per output byte (each may wait on the output), a flush step
// when a final byte flushes the window (not when it ends in a match) and a closing
// step. The input is taken only when the previous byte is finished. Pattern
// writes empty the window.
module stream_find_replace #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sfr_pkg::DATA_W-1:0]      i_s_tdata,   // [7:0] in_byte
    input  logic                            i_s_tlast,   // final_byte
    // output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sfr_pkg::DATA_W-1:0]      o_m_tdata,   // [7:0] out_byte
    output logic                            o_m_tlast,   // run_last
    output logic [1:0]                      o_m_tuser    // [0] byte_valid, [1] stream_end
);

    localparam int DW   = sfr_pkg::DATA_W;
    localparam int LenW = sfr_pkg::LEN_W;
    localparam int CW   = $clog2(MAX_PATTERN + 1);
    localparam int RIW  = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;
    localparam logic [LenW-1:0] MaxPat  = LenW'(MAX_PATTERN);
    localparam logic [LenW-1:0] MaxRep  = LenW'(MAX_REPLACE);
    localparam logic [CW-1:0]   TopCell = CW'(MAX_PATTERN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REPL,
        S_FLUSH,
        S_DONE
    } t_state;

    // configuration registers
    logic [sfr_pkg::CFG_DATA_W-1:0] r_pat;
    logic [LenW-1:0]                r_plen;
    logic [sfr_pkg::CFG_DATA_W-1:0] r_rep;
    logic [LenW-1:0]                r_rlen;

    // control and output state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_last, n_last;
    logic [RIW-1:0]  r_idx, n_idx;
    logic            r_pv, n_pv;
    logic [DW-1:0]   r_pb, n_pb;
    logic            r_ov, n_ov;
    logic [DW-1:0]   r_ob, n_ob;
    logic            r_obv, n_obv;
    logic            r_olast, n_olast;
    logic            r_oend, n_oend;

    logic [LenW-1:0] plen_eff;
    logic [LenW-1:0] rlen_eff;
    logic [CW-1:0]   widx;
    logic            accept;
    logic            pat_wr;
    logic            out_free;
    logic            can_emit;
    logic            prefix_ok;
    logic            pop;
    logic            emit_req;
    logic [DW-1:0]   emit_byte;

    logic [DW-1:0]          w_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;
    logic [MAX_PATTERN-1:0] w_used;

    // effective lengths, clamped to the built depths
    assign plen_eff = (r_plen > MaxPat) ? MaxPat : r_plen;
    assign rlen_eff = (r_rlen > MaxRep) ? MaxRep : r_rlen;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign widx       = (r_cnt > TopCell) ? TopCell : r_cnt;
    assign pat_wr     = i_cfg_we && ((i_cfg_idx == sfr_pkg::CFG_PATTERN_BYTES) ||
                                     (i_cfg_idx == sfr_pkg::CFG_PATTERN_LEN));

    // window row: cell i holds held byte i and shifts left on a pop
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic [DW-1:0] next_byte;
        if (i == MAX_PATTERN - 1) begin : g_end
            assign next_byte = w_byte[i];
        end else begin : g_mid
            assign next_byte = w_byte[i+1];
        end

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (accept && (widx == CW'(i))),
            .i_shift     (pop),
            .i_in_byte   (i_s_tdata),
            .i_next_byte (next_byte),
            .i_pat_byte  (r_pat[i*DW +: DW]),
            .o_byte      (w_byte[i]),
            .o_eq        (w_eq[i])
        );

        assign w_used[i] = (CW'(i) < r_cnt);
    end

    // window is a prefix of the pattern when it is no longer than the pattern and every used cell matches
    assign prefix_ok = (LenW'(r_cnt) <= plen_eff) && (&(~w_used | w_eq));

    assign out_free = !r_ov || i_m_tready;
    assign can_emit = !r_pv || out_free;

    // next-state logic
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_idx     = r_idx;
        n_pv      = r_pv;
        n_pb      = r_pb;
        n_ov      = r_ov && !i_m_tready;
        n_ob      = r_ob;
        n_obv     = r_obv;
        n_olast   = r_olast;
        n_oend    = r_oend;
        pop       = 1'b0;
        emit_req  = 1'b0;
        emit_byte = w_byte[0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt   = widx + CW'(1);
                    n_last  = i_s_tlast;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_cnt != '0) && !prefix_ok) begin
                    emit_req = 1'b1;
                    if (can_emit) begin
                        pop   = 1'b1;
                        n_cnt = r_cnt - CW'(1);
                    end
                end else if ((plen_eff != '0) && (LenW'(r_cnt) == plen_eff)) begin
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_state = (rlen_eff != '0) ? S_REPL : S_DONE;
                end else begin
                    n_state = r_last ? S_FLUSH : S_DONE;
                end
            end
            S_REPL: begin
                emit_req  = 1'b1;
                emit_byte = r_rep[DW*r_idx +: DW];
                if (can_emit) begin
                    n_idx = r_idx + RIW'(1);
                    if (LenW'(r_idx) == rlen_eff - LenW'(1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FLUSH: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    emit_req = 1'b1;
                    if (can_emit) begin
                        pop   = 1'b1;
                        n_cnt = r_cnt - CW'(1);
                    end
                end
            end
            S_DONE: begin
                // close the run: the pending byte or a bare end marker
                if (r_pv) begin
                    if (out_free) begin
                        n_ov    = 1'b1;
                        n_ob    = r_pb;
                        n_obv   = 1'b1;
                        n_olast = 1'b1;
                        n_oend  = r_last;
                        n_pv    = 1'b0;
                        n_state = S_IDLE;
                    end
                end else if (r_last) begin
                    if (out_free) begin
                        n_ov    = 1'b1;
                        n_ob    = '0;
                        n_obv   = 1'b0;
                        n_olast = 1'b1;
                        n_oend  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new byte goes to pending; the older pending byte moves out
        if (emit_req && can_emit) begin
            if (r_pv) begin
                n_ov    = 1'b1;
                n_ob    = r_pb;
                n_obv   = 1'b1;
                n_olast = 1'b0;
                n_oend  = 1'b0;
            end
            n_pv = 1'b1;
            n_pb = emit_byte;
        end

        // a pattern rewrite drops the window
        if (pat_wr) begin
            n_cnt = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
        r_pb    <= n_pb;
        r_ob    <= n_ob;
        r_obv   <= n_obv;
        r_olast <= n_olast;
        r_oend  <= n_oend;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfr_pkg::CFG_PATTERN_BYTES: r_pat  <= i_cfg_data;
                sfr_pkg::CFG_PATTERN_LEN:   r_plen <= i_cfg_data[LenW-1:0];
                sfr_pkg::CFG_REPLACE_BYTES: r_rep  <= i_cfg_data;
                sfr_pkg::CFG_REPLACE_LEN:   r_rlen <= i_cfg_data[LenW-1:0];
                default: ;
            endcase
        end
    end

    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = r_ob;
    assign o_m_tlast    = r_olast;
    assign o_m_tuser[0] = r_obv;
    assign o_m_tuser[1] = r_oend;

`ifndef ASSERT_OFF
    // window never holds more bytes than there are cells
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_PATTERN))
        else $error("window count above cell count");

    // between input bytes the window is shorter than the pattern
    a_idle_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_cnt == '0) || (LenW'(r_cnt) < plen_eff)))
        else $error("window not below pattern length between transactions");

    // nothing stays pending once a byte is finished
    a_idle_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending byte left after closing a run");

    // an accepted byte is scanned next
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted byte not scanned");
`endif

endmodule
